// ===== rtl/core/distance_pid_move_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// Distance PID move controller assertion macros
// Concurrent check macros used by the top-level RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_PID_MOVE_CONTROLLER_TOP_ASSERT_SVH
`define DISTANCE_PID_MOVE_CONTROLLER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// consequent holds in the same cycle as the antecedent
`define DPMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpmc check failed");

// consequent holds in the cycle after the antecedent
`define DPMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpmc check failed");

`else

`define DPMC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define DPMC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/dpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance PID move controller package
// Shared types, register codes, reset values and square root length.
// ----------------------------------------------------------------------------
package dpmc_pkg;

   typedef logic signed [31:0] q16_type;
   typedef logic [15:0]        gain_type;
   typedef logic [30:0]        gap_type;
   typedef logic [31:0]        mag_type;
   typedef logic signed [47:0] sum_type;
   typedef logic signed [63:0] prod_type;
   typedef logic [63:0]        rad_type;
   typedef logic [2:0]         csr_index_type;

   localparam csr_index_type CSR_GAIN_P    = 3'd0;
   localparam csr_index_type CSR_GAIN_I    = 3'd1;
   localparam csr_index_type CSR_GAIN_D    = 3'd2;
   localparam csr_index_type CSR_SAFE_GAP  = 3'd3;
   localparam csr_index_type CSR_DONE_BAND = 3'd4;

   localparam gain_type GAIN_P_RESET    = 16'd128;
   localparam gain_type GAIN_I_RESET    = 16'd0;
   localparam gain_type GAIN_D_RESET    = 16'd0;
   localparam gap_type  SAFE_GAP_RESET  = 31'd32768;
   localparam gap_type  DONE_BAND_RESET = 31'd6554;

   localparam int ROOT_STEPS = 32;
   localparam int ROOT_ITER  = (ROOT_STEPS < 32) ? ROOT_STEPS : 32;
   localparam int ROOT_PAD   = 32 - ROOT_ITER;
   localparam int ROOT_CNT_W = $clog2(ROOT_ITER + 1);

endpackage

// ===== rtl/core/distance_pid_move_controller_top.sv =====
// Timing: a tick that does not drive a move goes from idle straight to the output state;
// a moving tick is paced by the serial multiplier (one multiplier
// bit per cycle, up to five products) and the square root (one root bit per cycle, 32 steps).
// A new tick is taken only in idle, after the last result is loaded; a stalled result holds the next tick.
// Reset: synchronous, active high; clears flags, integral and last error, loads register reset values.
// ----------------------------------------------------------------------------
// Distance PID move controller
// Tracks position against a distance target and issues a PID speed command.
// ----------------------------------------------------------------------------
module distance_pid_move_controller_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_pos_valid,
   input  dpmc_pkg::q16_type        req_pos_x,
   input  dpmc_pkg::q16_type        req_pos_y,
   input  logic                     req_goal_valid,
   input  dpmc_pkg::q16_type        req_goal_dist,
   input  logic                     req_obst_valid,
   input  dpmc_pkg::q16_type        req_obst_x,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_speed_valid,
   output dpmc_pkg::q16_type        rsp_speed,
   output logic                     rsp_done_valid,
   output dpmc_pkg::gap_type        rsp_dist_done,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  dpmc_pkg::csr_index_type  csr_index,
   input  dpmc_pkg::gap_type        csr_wdata
);
   import dpmc_pkg::*;

   `include "distance_pid_move_controller_top_assert.svh"

   typedef logic signed [32:0] wide_type;
   typedef logic signed [41:0] acc_type;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DIFF      = 5'd1;
   localparam logic [4:0] S_ABS       = 5'd2;
   localparam logic [4:0] S_SQX_GO    = 5'd3;
   localparam logic [4:0] S_SQX_WAIT  = 5'd4;
   localparam logic [4:0] S_SQY_GO    = 5'd5;
   localparam logic [4:0] S_SQY_WAIT  = 5'd6;
   localparam logic [4:0] S_ROOT_GO   = 5'd7;
   localparam logic [4:0] S_ROOT_WAIT = 5'd8;
   localparam logic [4:0] S_ERR       = 5'd9;
   localparam logic [4:0] S_MAG       = 5'd10;
   localparam logic [4:0] S_CLAMP     = 5'd11;
   localparam logic [4:0] S_DECIDE    = 5'd12;
   localparam logic [4:0] S_SUM       = 5'd13;
   localparam logic [4:0] S_TERM_GO   = 5'd14;
   localparam logic [4:0] S_TERM_WAIT = 5'd15;
   localparam logic [4:0] S_TERM_ADD  = 5'd16;
   localparam logic [4:0] S_QUANT     = 5'd17;
   localparam logic [4:0] S_OUT       = 5'd18;

   localparam logic [1:0] TERM_P = 2'd0;
   localparam logic [1:0] TERM_I = 2'd1;
   localparam logic [1:0] TERM_D = 2'd2;

   localparam prod_type ACC_LIM   = 64'sh0000_0100_0000_0000;
   localparam prod_type ACC_LIM_N = -ACC_LIM;

   function automatic acc_type clamp_acc(input prod_type v);
      prod_type r;
      r = v;
      if (v > ACC_LIM) begin
         r = ACC_LIM;
      end else if (v < ACC_LIM_N) begin
         r = ACC_LIM_N;
      end
      return acc_type'(r);
   endfunction

   logic [4:0] state_ff, state_in;
   gain_type   gain_p_ff, gain_p_in, gain_i_ff, gain_i_in, gain_d_ff, gain_d_in;
   gap_type    safe_gap_ff, safe_gap_in, done_band_ff, done_band_in;
   q16_type    cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   q16_type    start_x_ff, start_x_in, start_y_ff, start_y_in;
   q16_type    goal_ff, goal_in, obst_ff, obst_in;
   logic       pos_seen_ff, pos_seen_in, obst_seen_ff, obst_seen_in;
   logic       pend_ff, pend_in, move_ff, move_in;
   sum_type    err_sum_ff, err_sum_in;
   q16_type    err_last_ff, err_last_in;
   wide_type   dx_ff, dx_in, dy_ff, dy_in;
   mag_type    dx_mag_ff, dx_mag_in, dy_mag_ff, dy_mag_in;
   rad_type    sq_ff, sq_in;
   gap_type    d_ff, d_in;
   wide_type   err_ff, err_in;
   mag_type    err_mag_ff, err_mag_in, obst_mag_ff, obst_mag_in;
   q16_type    err_fin_ff, err_fin_in;
   mag_type    mag_fin_ff, mag_fin_in;
   wide_type   deriv_ff, deriv_in;
   logic [1:0] term_idx_ff, term_idx_in;
   acc_type    term_ff, term_in, acc_ff, acc_in;
   logic       res_spd_v_ff, res_spd_v_in, res_done_v_ff, res_done_v_in;
   q16_type    res_speed_ff, res_speed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_speed_valid_ff, rsp_speed_valid_in;
   q16_type    rsp_speed_ff, rsp_speed_in;
   logic       rsp_done_valid_ff, rsp_done_valid_in;
   gap_type    rsp_dist_done_ff, rsp_dist_done_in;

   logic       pos_now, pend_now, obst_now, start_now, move_now;
   logic       sat, clamp, near, go_on;
   wide_type   dx_neg, dy_neg, err_neg, obst_neg;
   logic [48:0] sum_wide;
   logic signed [42:0] acc_sum;
   logic signed [33:0] q;

   logic       mul_start, mul_busy;
   sum_type    mul_mcand;
   mag_type    mul_mplier;
   prod_type   mul_prod;
   logic       sqrt_start, sqrt_busy;
   rad_type    sqrt_rad;
   mag_type    sqrt_root;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   assign sat        = dx_mag_ff[31] | dy_mag_ff[31];
   assign mul_start  = ((state_ff == S_SQX_GO) && !sat) || (state_ff == S_SQY_GO)
                       || (state_ff == S_TERM_GO);
   assign sqrt_start = (state_ff == S_ROOT_GO);
   assign sqrt_rad   = sq_ff + rad_type'(mul_prod);

   always_comb begin
      mul_mcand  = '0;
      mul_mplier = '0;
      unique case (state_ff)
         S_SQX_GO: begin
            mul_mcand  = {17'b0, dx_mag_ff[30:0]};
            mul_mplier = {1'b0, dx_mag_ff[30:0]};
         end
         S_SQY_GO: begin
            mul_mcand  = {17'b0, dy_mag_ff[30:0]};
            mul_mplier = {1'b0, dy_mag_ff[30:0]};
         end
         S_TERM_GO: begin
            unique case (term_idx_ff)
               TERM_P: begin
                  mul_mcand  = sum_type'(err_fin_ff);
                  mul_mplier = {16'b0, gain_p_ff};
               end
               TERM_I: begin
                  mul_mcand  = err_sum_ff;
                  mul_mplier = {16'b0, gain_i_ff};
               end
               TERM_D: begin
                  mul_mcand  = sum_type'(deriv_ff);
                  mul_mplier = {16'b0, gain_d_ff};
               end
               default: begin
                  mul_mcand  = '0;
                  mul_mplier = '0;
               end
            endcase
         end
         default: begin
            mul_mcand  = '0;
            mul_mplier = '0;
         end
      endcase
   end

   dpmc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .busy    (mul_busy),
      .product (mul_prod)
   );

   dpmc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (sqrt_rad),
      .busy  (sqrt_busy),
      .root  (sqrt_root)
   );

   always_comb begin
      state_in           = state_ff;
      gain_p_in          = gain_p_ff;
      gain_i_in          = gain_i_ff;
      gain_d_in          = gain_d_ff;
      safe_gap_in        = safe_gap_ff;
      done_band_in       = done_band_ff;
      cur_x_in           = cur_x_ff;
      cur_y_in           = cur_y_ff;
      start_x_in         = start_x_ff;
      start_y_in         = start_y_ff;
      goal_in            = goal_ff;
      obst_in            = obst_ff;
      pos_seen_in        = pos_seen_ff;
      obst_seen_in       = obst_seen_ff;
      pend_in            = pend_ff;
      move_in            = move_ff;
      err_sum_in         = err_sum_ff;
      err_last_in        = err_last_ff;
      dx_in              = dx_ff;
      dy_in              = dy_ff;
      dx_mag_in          = dx_mag_ff;
      dy_mag_in          = dy_mag_ff;
      sq_in              = sq_ff;
      d_in               = d_ff;
      err_in             = err_ff;
      err_mag_in         = err_mag_ff;
      obst_mag_in        = obst_mag_ff;
      err_fin_in         = err_fin_ff;
      mag_fin_in         = mag_fin_ff;
      deriv_in           = deriv_ff;
      term_idx_in        = term_idx_ff;
      term_in            = term_ff;
      acc_in             = acc_ff;
      res_spd_v_in       = res_spd_v_ff;
      res_done_v_in      = res_done_v_ff;
      res_speed_in       = res_speed_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_speed_valid_in = rsp_speed_valid_ff;
      rsp_speed_in       = rsp_speed_ff;
      rsp_done_valid_in  = rsp_done_valid_ff;
      rsp_dist_done_in   = rsp_dist_done_ff;

      pos_now   = pos_seen_ff | req_pos_valid;
      pend_now  = pend_ff | req_goal_valid;
      obst_now  = obst_seen_ff | req_obst_valid;
      start_now = pend_now & pos_now & obst_now;
      move_now  = move_ff | start_now;

      dx_neg   = -dx_ff;
      dy_neg   = -dy_ff;
      err_neg  = -err_ff;
      obst_neg = -{obst_ff[31], obst_ff};
      clamp    = obst_ff[31] || (err_mag_ff > {1'b0, obst_ff[30:0]});
      near     = obst_mag_ff < {1'b0, safe_gap_ff};
      go_on    = (mag_fin_ff > {1'b0, done_band_ff}) && !near;
      sum_wide = {err_sum_ff[47], err_sum_ff} + {{17{err_fin_ff[31]}}, err_fin_ff};
      acc_sum  = {acc_ff[41], acc_ff} + {term_ff[41], term_ff};
      q        = acc_ff[41:8];

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_P:    gain_p_in    = csr_wdata[15:0];
            CSR_GAIN_I:    gain_i_in    = csr_wdata[15:0];
            CSR_GAIN_D:    gain_d_in    = csr_wdata[15:0];
            CSR_SAFE_GAP:  safe_gap_in  = csr_wdata;
            CSR_DONE_BAND: done_band_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_pos_valid) begin
                  cur_x_in = req_pos_x;
                  cur_y_in = req_pos_y;
               end
               if (req_goal_valid) begin
                  goal_in = req_goal_dist;
               end
               if (req_obst_valid) begin
                  obst_in = req_obst_x;
               end
               pos_seen_in  = pos_now;
               obst_seen_in = obst_now;
               pend_in      = pend_now & ~start_now;
               move_in      = move_now;
               if (start_now) begin
                  start_x_in = req_pos_valid ? req_pos_x : cur_x_ff;
                  start_y_in = req_pos_valid ? req_pos_y : cur_y_ff;
               end
               if (pos_now && move_now && obst_now) begin
                  state_in = S_DIFF;
               end else begin
                  res_spd_v_in  = 1'b0;
                  res_speed_in  = '0;
                  res_done_v_in = 1'b0;
                  state_in      = S_OUT;
               end
            end
         end
         S_DIFF: begin
            dx_in    = {cur_x_ff[31], cur_x_ff} - {start_x_ff[31], start_x_ff};
            dy_in    = {cur_y_ff[31], cur_y_ff} - {start_y_ff[31], start_y_ff};
            state_in = S_ABS;
         end
         S_ABS: begin
            dx_mag_in = dx_ff[32] ? dx_neg[31:0] : dx_ff[31:0];
            dy_mag_in = dy_ff[32] ? dy_neg[31:0] : dy_ff[31:0];
            state_in  = S_SQX_GO;
         end
         S_SQX_GO: begin
            if (sat) begin
               d_in     = '1;
               state_in = S_ERR;
            end else begin
               state_in = S_SQX_WAIT;
            end
         end
         S_SQX_WAIT: begin
            if (!mul_busy) begin
               sq_in    = rad_type'(mul_prod);
               state_in = S_SQY_GO;
            end
         end
         S_SQY_GO: begin
            state_in = S_SQY_WAIT;
         end
         S_SQY_WAIT: begin
            if (!mul_busy) begin
               state_in = S_ROOT_GO;
            end
         end
         S_ROOT_GO: begin
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (!sqrt_busy) begin
               d_in     = sqrt_root[31] ? '1 : sqrt_root[30:0];
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            err_in      = {goal_ff[31], goal_ff} - {2'b00, d_ff};
            obst_mag_in = obst_ff[31] ? obst_neg[31:0] : {1'b0, obst_ff[30:0]};
            state_in    = S_MAG;
         end
         S_MAG: begin
            err_mag_in = err_ff[32] ? err_neg[31:0] : err_ff[31:0];
            state_in   = S_CLAMP;
         end
         S_CLAMP: begin
            err_fin_in = clamp ? obst_ff : err_ff[31:0];
            mag_fin_in = clamp ? obst_mag_ff : err_mag_ff;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            if (go_on) begin
               state_in = S_SUM;
            end else begin
               res_spd_v_in  = 1'b1;
               res_speed_in  = '0;
               res_done_v_in = 1'b1;
               move_in       = 1'b0;
               obst_seen_in  = 1'b0;
               state_in      = S_OUT;
            end
         end
         S_SUM: begin
            if (sum_wide[48] != sum_wide[47]) begin
               err_sum_in = sum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            end else begin
               err_sum_in = sum_wide[47:0];
            end
            deriv_in    = {err_fin_ff[31], err_fin_ff} - {err_last_ff[31], err_last_ff};
            err_last_in = err_fin_ff;
            acc_in      = '0;
            term_idx_in = TERM_P;
            state_in    = S_TERM_GO;
         end
         S_TERM_GO: begin
            state_in = S_TERM_WAIT;
         end
         S_TERM_WAIT: begin
            if (!mul_busy) begin
               term_in  = clamp_acc(mul_prod);
               state_in = S_TERM_ADD;
            end
         end
         S_TERM_ADD: begin
            acc_in = clamp_acc(prod_type'(acc_sum));
            if (term_idx_ff == TERM_D) begin
               state_in = S_QUANT;
            end else begin
               term_idx_in = term_idx_ff + 1'b1;
               state_in    = S_TERM_GO;
            end
         end
         S_QUANT: begin
            if ((q[33:31] == 3'b000) || (q[33:31] == 3'b111)) begin
               res_speed_in = q[31:0];
            end else begin
               res_speed_in = q[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            res_spd_v_in  = 1'b1;
            res_done_v_in = 1'b0;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_speed_valid_in = res_spd_v_ff;
               rsp_speed_in       = res_speed_ff;
               rsp_done_valid_in  = res_done_v_ff;
               rsp_dist_done_in   = res_done_v_ff ? d_ff : '0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         safe_gap_ff  <= SAFE_GAP_RESET;
         done_band_ff <= DONE_BAND_RESET;
         pos_seen_ff  <= 1'b0;
         obst_seen_ff <= 1'b0;
         pend_ff      <= 1'b0;
         move_ff      <= 1'b0;
         err_sum_ff   <= '0;
         err_last_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         safe_gap_ff  <= safe_gap_in;
         done_band_ff <= done_band_in;
         pos_seen_ff  <= pos_seen_in;
         obst_seen_ff <= obst_seen_in;
         pend_ff      <= pend_in;
         move_ff      <= move_in;
         err_sum_ff   <= err_sum_in;
         err_last_ff  <= err_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff           <= cur_x_in;
      cur_y_ff           <= cur_y_in;
      start_x_ff         <= start_x_in;
      start_y_ff         <= start_y_in;
      goal_ff            <= goal_in;
      obst_ff            <= obst_in;
      dx_ff              <= dx_in;
      dy_ff              <= dy_in;
      dx_mag_ff          <= dx_mag_in;
      dy_mag_ff          <= dy_mag_in;
      sq_ff              <= sq_in;
      d_ff               <= d_in;
      err_ff             <= err_in;
      err_mag_ff         <= err_mag_in;
      obst_mag_ff        <= obst_mag_in;
      err_fin_ff         <= err_fin_in;
      mag_fin_ff         <= mag_fin_in;
      deriv_ff           <= deriv_in;
      term_idx_ff        <= term_idx_in;
      term_ff            <= term_in;
      acc_ff             <= acc_in;
      res_spd_v_ff       <= res_spd_v_in;
      res_done_v_ff      <= res_done_v_in;
      res_speed_ff       <= res_speed_in;
      rsp_speed_valid_ff <= rsp_speed_valid_in;
      rsp_speed_ff       <= rsp_speed_in;
      rsp_done_valid_ff  <= rsp_done_valid_in;
      rsp_dist_done_ff   <= rsp_dist_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_valid = rsp_speed_valid_ff;
   assign rsp_speed       = rsp_speed_ff;
   assign rsp_done_valid  = rsp_done_valid_ff;
   assign rsp_dist_done   = rsp_dist_done_ff;

   `DPMC_ASSERT_IMPLY(a_done_stops, clock, reset, rsp_valid_ff && rsp_done_valid_ff,
      rsp_speed_valid_ff && (rsp_speed_ff == '0))
   `DPMC_ASSERT_IMPLY(a_dist_on_done, clock, reset, rsp_valid_ff && !rsp_done_valid_ff,
      rsp_dist_done_ff == '0)
   `DPMC_ASSERT_IMPLY(a_idle_units_quiet, clock, reset, state_ff == S_IDLE,
      !mul_busy && !sqrt_busy)
   `DPMC_ASSERT_NEXT(a_transfer_leaves_idle, clock, reset, req_valid && req_ready,
      state_ff != S_IDLE)
   `DPMC_ASSERT_IMPLY(a_move_has_pos, clock, reset, move_ff, pos_seen_ff)

endmodule

// ===== rtl/core/dpmc_mul.sv =====
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dpmc_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dpmc_pkg::sum_type  mcand,
   input  dpmc_pkg::mag_type  mplier,
   output logic               busy,
   output dpmc_pkg::prod_type product
);
   import dpmc_pkg::*;

   logic     busy_ff, busy_in;
   prod_type mcand_ff, mcand_in;
   mag_type  mplier_ff, mplier_in;
   prod_type prod_ff, prod_in;

   always_comb begin
      busy_in   = busy_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      priority if (start) begin
         busy_in   = 1'b1;
         mcand_in  = prod_type'(mcand);
         mplier_in = mplier;
         prod_in   = '0;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign busy    = busy_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/core/dpmc_sqrt.sv =====
// ----------------------------------------------------------------------------
// Serial integer square root
// Restoring digit recurrence, two radicand bits in and one root bit out a cycle.
// ----------------------------------------------------------------------------
module dpmc_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dpmc_pkg::rad_type rad,
   output logic              busy,
   output dpmc_pkg::mag_type root
);
   import dpmc_pkg::*;

   localparam int REM_W = 34;

   logic                  busy_ff, busy_in;
   rad_type               rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   mag_type               root_ff, root_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W+1:0]      rem_sh;
   logic [REM_W+1:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      rem_sh  = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      priority if (start) begin
         busy_in = 1'b1;
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = ROOT_CNT_W'(ROOT_ITER);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (rem_sh >= trial) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_sh);
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff << ROOT_PAD;

endmodule
